// File: rtl/assert_macros.svh
// Assertion macros shared by the relay RTL.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_AT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// File: rtl/mnqs_pkg.sv
// Package for the multi-node queue and stack relay: sizes, codes, types.
// Used by mnqs_ctrl, mnqs_dpath and multi_node_queue_stack_relay; no dependencies.
package mnqs_pkg;

  // Sizes.
  localparam int unsigned Nodes      = 8;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned StackDepth = 16;

  // Field widths fixed by the interface.
  localparam int unsigned NodeW = 3;
  localparam int unsigned ValW  = 8;
  localparam int unsigned KindW = 2;
  localparam int unsigned CapW  = 5;
  localparam int unsigned CfgW  = 40;
  localparam int unsigned CfgIdxW = 2;

  // Derived widths.
  localparam int unsigned NodeIdxW = $clog2(Nodes);
  localparam int unsigned QPtrW    = $clog2(QueueDepth);
  localparam int unsigned QCntW    = $clog2(QueueDepth + 1);
  localparam int unsigned SPtrW    = $clog2(StackDepth);
  localparam int unsigned SCntW    = $clog2(StackDepth + 1);
  localparam int unsigned QAddrW   = NodeIdxW + QPtrW;
  localparam int unsigned SAddrW   = NodeIdxW + SPtrW;

  // Register reset values.
  localparam logic [NodeW-1:0] SrvReset = NodeW'(7);
  localparam logic [CfgW-1:0]  CapReset = 40'd567489872400;

  typedef enum logic [KindW-1:0] {
    CmdAdd   = 2'd0,
    CmdPush  = 2'd1,
    CmdSend  = 2'd2,
    CmdServe = 2'd3
  } cmd_kind_e;

  typedef enum logic [KindW-1:0] {
    EntByte   = 2'd0,
    EntQFull  = 2'd1,
    EntSFull  = 2'd2,
    EntQEmpty = 2'd3
  } entry_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgServer = 2'd0,
    CfgQCap   = 2'd1,
    CfgSCap   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StLook,
    StRead,
    StByte,
    StPut,
    StFull
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        load;        // latch the accepted word
    logic        sel_srv;     // point the working node at the server
    logic        q_write;     // enqueue on the working node
    logic        s_write;     // push on the working node
    logic        q_read;      // dequeue from the working node
    logic        s_read;      // pop from the working node
    logic        cap_byte;    // capture the memory read data
    logic        emit;        // load the output register
    entry_kind_e emit_kind;
    logic        emit_last;
    logic        emit_byte;   // entry carries the captured byte
    logic        emit_client; // entry is tagged with the command's node
    logic        put_byte;    // enqueue the captured byte, not the input byte
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_kind_e kind;
    logic      tgt_ok;
    logic      q_full;
    logic      s_full;
    logic      q_empty;
    logic      s_empty;
    logic      out_free;
  } dp_stat_t;

  // Effective queue capacity: zero acts as one, clamped to the depth.
  function automatic logic [QCntW-1:0] q_cap(input logic [CfgW-1:0] caps,
                                             input logic [NodeIdxW-1:0] n);
    logic [CapW-1:0] f;
    f = caps[CapW*n +: CapW];
    if (f == '0) begin
      return QCntW'(1);
    end else if (32'(f) > QueueDepth) begin
      return QCntW'(QueueDepth);
    end
    return QCntW'(f);
  endfunction

  // Effective stack capacity, clamped to the depth.
  function automatic logic [SCntW-1:0] s_cap(input logic [CfgW-1:0] caps,
                                             input logic [NodeIdxW-1:0] n);
    logic [CapW-1:0] f;
    f = caps[CapW*n +: CapW];
    if (32'(f) > StackDepth) begin
      return SCntW'(StackDepth);
    end
    return SCntW'(f);
  endfunction

  // Circular pointer advance that wraps at the capacity.
  function automatic logic [QPtrW-1:0] q_next(input logic [QPtrW-1:0] ptr,
                                              input logic [QCntW-1:0] cap);
    logic [QCntW-1:0] nxt;
    nxt = QCntW'(ptr) + QCntW'(1);
    if (nxt >= cap) begin
      return '0;
    end
    return nxt[QPtrW-1:0];
  endfunction

endpackage

// File: rtl/mnqs_ctrl.sv
// Controller state machine of the relay: sequences lookups, memory accesses and log words.
// Depends on mnqs_pkg; drives mnqs_dpath through dp_cmd_t and reads dp_stat_t.
module mnqs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  mnqs_pkg::dp_stat_t stat_i,
  output mnqs_pkg::dp_cmd_t  cmd_o
);

  mnqs_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mnqs_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      mnqs_pkg::StIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = mnqs_pkg::StLook;
        end
      end
      mnqs_pkg::StLook: begin
        if (!stat_i.tgt_ok) begin
          state_d = mnqs_pkg::StIdle;
        end else begin
          unique case (stat_i.kind)
            mnqs_pkg::CmdAdd: begin
              if (!stat_i.q_full) begin
                cmd_o.q_write = 1'b1;
                state_d       = mnqs_pkg::StIdle;
              end else if (stat_i.out_free) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_kind = mnqs_pkg::EntQFull;
                cmd_o.emit_last = 1'b1;
                state_d         = mnqs_pkg::StIdle;
              end
            end
            mnqs_pkg::CmdPush: begin
              if (!stat_i.s_full) begin
                cmd_o.s_write = 1'b1;
                state_d       = mnqs_pkg::StIdle;
              end else if (stat_i.out_free) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_kind = mnqs_pkg::EntSFull;
                cmd_o.emit_last = 1'b1;
                state_d         = mnqs_pkg::StIdle;
              end
            end
            default: begin
              // Send and serve take the stack top first, then the queue head.
              if (!stat_i.s_empty) begin
                cmd_o.s_read = 1'b1;
                state_d      = mnqs_pkg::StRead;
              end else if (!stat_i.q_empty) begin
                cmd_o.q_read = 1'b1;
                state_d      = mnqs_pkg::StRead;
              end else if (stat_i.out_free) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_kind = mnqs_pkg::EntQEmpty;
                cmd_o.emit_last = 1'b1;
                state_d         = mnqs_pkg::StIdle;
              end
            end
          endcase
        end
      end
      mnqs_pkg::StRead: begin
        cmd_o.cap_byte = 1'b1;
        if (stat_i.kind == mnqs_pkg::CmdSend) begin
          cmd_o.sel_srv = 1'b1;
          state_d       = mnqs_pkg::StPut;
        end else begin
          state_d = mnqs_pkg::StByte;
        end
      end
      mnqs_pkg::StByte: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = mnqs_pkg::EntByte;
          cmd_o.emit_byte = 1'b1;
          cmd_o.emit_last = 1'b1;
          state_d         = mnqs_pkg::StIdle;
        end
      end
      mnqs_pkg::StPut: begin
        // The removed byte is logged on the client; it is the last word
        // unless the server queue turns it away.
        if (stat_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_kind   = mnqs_pkg::EntByte;
          cmd_o.emit_byte   = 1'b1;
          cmd_o.emit_client = 1'b1;
          cmd_o.emit_last   = !stat_i.q_full;
          if (stat_i.q_full) begin
            state_d = mnqs_pkg::StFull;
          end else begin
            cmd_o.q_write  = 1'b1;
            cmd_o.put_byte = 1'b1;
            state_d        = mnqs_pkg::StIdle;
          end
        end
      end
      mnqs_pkg::StFull: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = mnqs_pkg::EntQFull;
          cmd_o.emit_last = 1'b1;
          state_d         = mnqs_pkg::StIdle;
        end
      end
      default: begin
        state_d = mnqs_pkg::StIdle;
      end
    endcase
  end

endmodule

// File: rtl/mnqs_dpath.sv
// Datapath of the relay: configuration, per-node pointers, byte memories, output register.
// Depends on mnqs_pkg and assert_macros.svh; commanded by mnqs_ctrl.
`include "assert_macros.svh"

module mnqs_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mnqs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mnqs_pkg::CfgW-1:0]     cfg_data_i,
  input  logic [mnqs_pkg::KindW-1:0]    in_kind_i,
  input  logic [mnqs_pkg::NodeW-1:0]    in_node_i,
  input  logic [mnqs_pkg::ValW-1:0]     in_value_i,
  input  mnqs_pkg::dp_cmd_t             cmd_i,
  output mnqs_pkg::dp_stat_t            stat_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [mnqs_pkg::NodeW-1:0]    out_node_o,
  output logic [mnqs_pkg::KindW-1:0]    out_kind_o,
  output logic [mnqs_pkg::ValW-1:0]     out_value_o,
  output logic                          out_last_o
);

  localparam int unsigned QWords = mnqs_pkg::Nodes * mnqs_pkg::QueueDepth;
  localparam int unsigned SWords = mnqs_pkg::Nodes * mnqs_pkg::StackDepth;

  // Configuration registers.
  logic [mnqs_pkg::NodeW-1:0] srv_q;
  logic [mnqs_pkg::CfgW-1:0]  qcaps_q;
  logic [mnqs_pkg::CfgW-1:0]  scaps_q;

  // Per-node pointers and counts.
  logic [mnqs_pkg::QPtrW-1:0] qhead_q [mnqs_pkg::Nodes];
  logic [mnqs_pkg::QPtrW-1:0] qtail_q [mnqs_pkg::Nodes];
  logic [mnqs_pkg::QCntW-1:0] qcnt_q  [mnqs_pkg::Nodes];
  logic [mnqs_pkg::SCntW-1:0] scnt_q  [mnqs_pkg::Nodes];

  // Byte memories.
  logic [mnqs_pkg::ValW-1:0] qmem [QWords];
  logic [mnqs_pkg::ValW-1:0] smem [SWords];
  logic [mnqs_pkg::ValW-1:0] qrd_q, srd_q;
  logic                      src_stack_q;

  // Latched command word and working registers.
  mnqs_pkg::cmd_kind_e          kind_q;
  logic [mnqs_pkg::NodeW-1:0]   node_q;
  logic [mnqs_pkg::ValW-1:0]    value_q;
  logic [mnqs_pkg::NodeIdxW-1:0] cur_q;
  logic [mnqs_pkg::ValW-1:0]    byte_q;

  // Output register.
  logic                       out_valid_q;
  logic [mnqs_pkg::NodeW-1:0] out_node_q;
  logic [mnqs_pkg::KindW-1:0] out_kind_q;
  logic [mnqs_pkg::ValW-1:0]  out_value_q;
  logic                       out_last_q;

  logic [mnqs_pkg::NodeIdxW-1:0] srv_idx;
  logic [mnqs_pkg::QPtrW-1:0]    hd, tl;
  logic [mnqs_pkg::QCntW-1:0]    qcnt, qcnt_dec, qcap;
  logic [mnqs_pkg::SCntW-1:0]    scnt, scnt_dec, scap;
  logic [mnqs_pkg::SPtrW-1:0]    sidx_rd;
  logic [mnqs_pkg::ValW-1:0]     wdata;
  logic                          node_ok, srv_ok;
  logic                          q_full, s_full, q_empty, s_empty, out_free;

  // Working node lookups.
  assign srv_idx  = srv_q[mnqs_pkg::NodeIdxW-1:0];
  assign hd       = qhead_q[cur_q];
  assign tl       = qtail_q[cur_q];
  assign qcnt     = qcnt_q[cur_q];
  assign scnt     = scnt_q[cur_q];
  assign qcnt_dec = qcnt - mnqs_pkg::QCntW'(1);
  assign scnt_dec = scnt - mnqs_pkg::SCntW'(1);
  assign sidx_rd  = scnt_dec[mnqs_pkg::SPtrW-1:0];
  assign qcap     = mnqs_pkg::q_cap(qcaps_q, cur_q);
  assign scap     = mnqs_pkg::s_cap(scaps_q, cur_q);
  assign wdata    = cmd_i.put_byte ? byte_q : value_q;

  // Status toward the controller.
  assign node_ok  = 32'(node_q) < mnqs_pkg::Nodes;
  assign srv_ok   = 32'(srv_q) < mnqs_pkg::Nodes;
  assign q_full   = qcnt >= qcap;
  assign s_full   = scnt >= scap;
  assign q_empty  = qcnt == '0;
  assign s_empty  = scnt == '0;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    stat_o          = '0;
    stat_o.kind     = kind_q;
    stat_o.tgt_ok   = (kind_q == mnqs_pkg::CmdServe) ? srv_ok :
                      (node_ok && ((kind_q != mnqs_pkg::CmdSend) || srv_ok));
    stat_o.q_full   = q_full;
    stat_o.s_full   = s_full;
    stat_o.q_empty  = q_empty;
    stat_o.s_empty  = s_empty;
    stat_o.out_free = out_free;
  end

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srv_q   <= mnqs_pkg::SrvReset;
      qcaps_q <= mnqs_pkg::CapReset;
      scaps_q <= mnqs_pkg::CapReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mnqs_pkg::CfgServer: srv_q   <= cfg_data_i[mnqs_pkg::NodeW-1:0];
        mnqs_pkg::CfgQCap:   qcaps_q <= cfg_data_i;
        mnqs_pkg::CfgSCap:   scaps_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Command word and working node.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= mnqs_pkg::cmd_kind_e'(in_kind_i);
      node_q  <= in_node_i;
      value_q <= in_value_i;
      cur_q   <= (mnqs_pkg::cmd_kind_e'(in_kind_i) == mnqs_pkg::CmdServe) ?
                 srv_idx : in_node_i[mnqs_pkg::NodeIdxW-1:0];
    end else if (cmd_i.sel_srv) begin
      cur_q <= srv_idx;
    end
    if (cmd_i.cap_byte) begin
      byte_q <= src_stack_q ? srd_q : qrd_q;
    end
  end

  // Queue and stack pointer updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mnqs_pkg::Nodes; i++) begin
        qhead_q[i] <= '0;
        qtail_q[i] <= '0;
        qcnt_q[i]  <= '0;
        scnt_q[i]  <= '0;
      end
    end else begin
      if (cmd_i.q_write) begin
        qtail_q[cur_q] <= mnqs_pkg::q_next(tl, qcap);
        qcnt_q[cur_q]  <= qcnt + mnqs_pkg::QCntW'(1);
      end
      if (cmd_i.q_read) begin
        qcnt_q[cur_q] <= qcnt_dec;
        if (qcnt_dec == '0) begin
          qhead_q[cur_q] <= '0;
          qtail_q[cur_q] <= '0;
        end else begin
          qhead_q[cur_q] <= mnqs_pkg::q_next(hd, qcap);
        end
      end
      if (cmd_i.s_write) begin
        scnt_q[cur_q] <= scnt + mnqs_pkg::SCntW'(1);
      end else if (cmd_i.s_read) begin
        scnt_q[cur_q] <= scnt_dec;
      end
    end
  end

  // Queue memory: one write or one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.q_write) begin
      qmem[{cur_q, tl}] <= wdata;
    end
    if (cmd_i.q_read) begin
      qrd_q <= qmem[{cur_q, hd}];
    end
  end

  // Stack memory: one write or one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.s_write) begin
      smem[{cur_q, scnt[mnqs_pkg::SPtrW-1:0]}] <= value_q;
    end
    if (cmd_i.s_read) begin
      srd_q <= smem[{cur_q, sidx_rd}];
    end
    if (cmd_i.q_read || cmd_i.s_read) begin
      src_stack_q <= cmd_i.s_read;
    end
  end

  // Output register: holds one log word until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_node_q  <= cmd_i.emit_client ? node_q : mnqs_pkg::NodeW'(cur_q);
      out_kind_q  <= cmd_i.emit_kind;
      out_value_q <= cmd_i.emit_byte ? byte_q : '0;
      out_last_q  <= cmd_i.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_node_o  = out_node_q;
  assign out_kind_o  = out_kind_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

  // A new word never overwrites one that has not been taken.
  `ASSERT_AT(a_emit_free, cmd_i.emit |-> out_free, "log word overwritten")
  // Enqueue only below capacity.
  `ASSERT_NEVER(a_qwr_full, cmd_i.q_write && q_full, "enqueue on full queue")
  // Pop only a stack that holds bytes.
  `ASSERT_NEVER(a_srd_empty, cmd_i.s_read && s_empty, "pop from empty stack")
  // The byte is captured in the cycle after a memory read.
  `ASSERT_AT(a_cap_after_rd, cmd_i.cap_byte |-> $past(cmd_i.q_read || cmd_i.s_read),
             "byte captured without a read")

endmodule

// File: rtl/multi_node_queue_stack_relay.sv
// Top level of the multi-node queue and stack relay.
// Depends on mnqs_pkg, mnqs_ctrl and mnqs_dpath.
//
//   Channel  Direction  Contents
//   s_axis   in         command word: tuser kind, tdata node and value
//   m_axis   out        log word: tuser entry kind, tdata node and value, tlast
//   cfg      in         register write: index and data, no read-back
//
// An add or push is looked up, then written; a serve or send reads the byte and logs it;
// a send also queues it at the server or logs that queue full. Memories are single-ported.
// A log word waits in the output register while the next command is taken.
// After reset all queues and stacks are empty; the server is node 7 and all
// capacities are 16. A stalled output holds the controller in its emit state.
module multi_node_queue_stack_relay (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mnqs_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mnqs_pkg::CfgW-1:0]         cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,  // node[2:0], value[10:3], zero
  input  logic [mnqs_pkg::KindW-1:0]        s_axis_tuser,  // kind[1:0]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [15:0]                       m_axis_tdata,  // log_node[2:0], log_value[10:3]
  output logic [mnqs_pkg::KindW-1:0]        m_axis_tuser,  // entry_kind[1:0]
  output logic                              m_axis_tlast
);

  mnqs_pkg::dp_cmd_t  cmd;
  mnqs_pkg::dp_stat_t stat;

  logic [mnqs_pkg::NodeW-1:0] out_node;
  logic [mnqs_pkg::ValW-1:0]  out_value;

  mnqs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  mnqs_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_kind_i   (s_axis_tuser),
    .in_node_i   (s_axis_tdata[mnqs_pkg::NodeW-1:0]),
    .in_value_i  (s_axis_tdata[mnqs_pkg::NodeW +: mnqs_pkg::ValW]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_node_o  (out_node),
    .out_kind_o  (m_axis_tuser),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast)
  );

  // Pack the log word, zero filled to whole bytes.
  assign m_axis_tdata = {5'b0, out_value, out_node};

endmodule
